FILE: rtl/rms_pkg.sv
// Package for the running mean and standard deviation core.
// Holds widths, operation codes, the queue entry type and the result type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rms_pkg;
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 24;
  localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
  localparam int SQ_BITS     = 2 * SAMPLE_BITS + COUNT_BITS;
  localparam int PROD_BITS   = SQ_BITS + COUNT_BITS;
  localparam int RAD_BITS    = PROD_BITS + 16;
  localparam int ROOT_BITS   = RAD_BITS / 2 + 1;
  localparam int OUT_BITS    = 24;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic [COUNT_BITS-1:0] n;
    logic signed [SUM_BITS-1:0] sum;
    logic [SQ_BITS-1:0] sumsq;
    logic dropped;
  } snap_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] count;
    logic signed [OUT_BITS-1:0] mean;
    logic [OUT_BITS-1:0] sd;
    logic dropped;
  } res_t;
endpackage
`default_nettype wire

FILE: rtl/rms_front.sv
// Front end: accepts items, updates count, sum and sum of squares.
// Pushes a snapshot of the statistics into a two-entry queue. Uses rms_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rms_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic op,
  input  wire logic signed [15:0] sample,
  output logic q_valid,
  output rms_pkg::snap_t q_data,
  input  wire logic q_pop
);
  logic [rms_pkg::COUNT_BITS-1:0] n;
  logic signed [rms_pkg::SUM_BITS-1:0] sum;
  logic [rms_pkg::SQ_BITS-1:0] sumsq;
  rms_pkg::snap_t mem [2];
  logic wp, rp;
  logic [1:0] fill;
  logic push, sat;
  logic signed [rms_pkg::SAMPLE_BITS-1:0] s;
  logic [2*rms_pkg::SAMPLE_BITS-1:0] sq;
  rms_pkg::snap_t nx;

  assign in_stall = (fill == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (fill != 2'd0);
  assign q_data = mem[rp];
  assign sat = (n == {rms_pkg::COUNT_BITS{1'b1}});
  assign s = sample[rms_pkg::SAMPLE_BITS-1:0];
  assign sq = $unsigned(32'(s) * 32'(s));

  always_comb begin
    nx.n = n; nx.sum = sum; nx.sumsq = sumsq; nx.dropped = 1'b0;
    if (op == rms_pkg::OP_CLEAR) begin
      nx.n = '0; nx.sum = '0; nx.sumsq = '0;
    end else if (sat) begin
      nx.dropped = 1'b1;
    end else begin
      nx.n = n + 1'b1;
      nx.sum = sum + rms_pkg::SUM_BITS'(s);
      nx.sumsq = sumsq + rms_pkg::SQ_BITS'(sq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0; sum <= '0; sumsq <= '0; wp <= 1'b0; rp <= 1'b0; fill <= '0;
    end else begin
      if (push) begin
        n <= nx.n; sum <= nx.sum; sumsq <= nx.sumsq;
        wp <= ~wp;
      end
      if (q_pop) rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
    if (push) mem[wp] <= nx;
  end
endmodule
`default_nettype wire

FILE: rtl/rms_back.sv
// Back end: computes mean and standard deviation from one snapshot with a
// sequencer, 24x32/24x40 multipliers, restoring divider, bit-serial root.
`timescale 1ns / 1ps
`default_nettype none
module rms_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire rms_pkg::snap_t q_data,
  output logic q_pop,
  output logic out_valid,
  input  wire logic out_stall,
  output rms_pkg::res_t res
);
  localparam int CB = rms_pkg::COUNT_BITS;
  localparam int SB = rms_pkg::SUM_BITS;
  localparam int QB = rms_pkg::SQ_BITS;
  localparam int PB = rms_pkg::PROD_BITS;
  localparam int RB = rms_pkg::RAD_BITS;
  localparam int TB = rms_pkg::ROOT_BITS;
  localparam int MB = SB + 8;
  localparam int CH = 32;
  localparam int NCH = (QB + CH - 1) / CH;
  localparam int DW = (MB > TB ? MB : TB);
  localparam int MEAN_MAX = (1 << (rms_pkg::OUT_BITS - 1)) - 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_MULA = 7'b0000010, S_MULB = 7'b0000100,
    S_SQRT = 7'b0001000, S_DIVM = 7'b0010000, S_DIVS = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;
  state_t st;

  rms_pkg::snap_t cur;
  logic neg;
  logic [SB-1:0] mag;
  logic [PB-1:0] acc_a, acc_b;
  logic [7:0] idx;
  logic [RB-1:0] rx;
  logic [TB+1:0] rrem;
  logic [TB-1:0] root;
  logic [DW-1:0] dq;
  logic [CB:0] drem;
  logic [CB+CH-1:0] prod;
  logic [CH-1:0] mop_b;
  logic [CB-1:0] mop_a;
  logic [TB+1:0] rtrial;
  logic [CB:0] dtrial;
  logic [MB-1:0] q_mean;
  logic [rms_pkg::OUT_BITS-1:0] mean_mag;
  logic signed [rms_pkg::OUT_BITS-1:0] mean_r;
  logic [TB-1:0] sd_q;

  assign neg = cur.sum[SB-1];
  assign mag = neg ? SB'(-cur.sum) : cur.sum;
  assign q_pop = (st == S_IDLE) && q_valid;
  assign prod = mop_a * mop_b;

  always_comb begin
    mop_a = cur.n; mop_b = '0;
    if (st == S_MULA) begin
      mop_b = CH'((PB + CH)'(cur.sumsq) >> (idx * CH));
    end
  end

  // Squaring of the magnitude walks one 24-bit digit of it per cycle. The
  // step after the last digit adds zero, so acc_b is complete when the
  // radicand is formed.
  logic [CB-1:0] mdig;
  logic [3:0] mi, mj;
  logic [CB+SB-1:0] bprod;
  assign mi = idx[7:4];
  assign mj = idx[3:0];
  assign mdig = CB'({{CB{1'b0}}, mag} >> (mi * CB));
  assign bprod = mdig * mag;

  assign rtrial = {rrem[TB-1:0], rx[RB-1 -: 2]} - {root, 2'b01};
  assign dtrial = {drem[CB-1:0], dq[DW-1]} - {1'b0, cur.n};
  assign q_mean = MB'(dq);
  assign sd_q = TB'(dq);
  assign mean_mag = (q_mean > MB'(MEAN_MAX + (neg ? 1 : 0))) ?
                    rms_pkg::OUT_BITS'(MEAN_MAX + (neg ? 1 : 0)) :
                    rms_pkg::OUT_BITS'(q_mean);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (st)
        S_IDLE: if (q_pop) begin
          cur <= q_data; idx <= '0; acc_a <= '0; acc_b <= '0;
          st <= S_MULA;
        end
        S_MULA: begin
          acc_a <= acc_a + PB'((PB + CH*NCH)'(prod) << (idx * CH));
          if (idx == 8'(NCH - 1)) begin
            idx <= '0; st <= S_MULB;
          end else idx <= idx + 1'b1;
        end
        S_MULB: begin
          acc_b <= acc_b + PB'((PB + 16*CB)'(bprod) << (mi * CB));
          if (32'(mi) > (SB - 1) / CB) begin
            rx <= (acc_a >= acc_b) ? RB'(acc_a - acc_b) << 16 : '0;
            rrem <= '0; root <= '0; idx <= '0; st <= S_SQRT;
          end else idx <= {mi + 1'b1, 4'd0};
        end
        S_SQRT: begin
          rx <= rx << 2;
          if (!rtrial[TB+1]) begin
            rrem <= rtrial; root <= {root[TB-2:0], 1'b1};
          end else begin
            rrem <= {rrem[TB-1:0], rx[RB-1 -: 2]}; root <= {root[TB-2:0], 1'b0};
          end
          if (idx == 8'(RB / 2 - 1)) begin
            idx <= '0; drem <= '0; dq <= DW'({mag, 8'd0}) << (DW - MB);
            st <= S_DIVM;
          end else idx <= idx + 1'b1;
        end
        S_DIVM: begin
          if (!dtrial[CB]) begin
            drem <= dtrial; dq <= {dq[DW-2:0], 1'b1};
          end else begin
            drem <= {drem[CB-1:0], dq[DW-1]}; dq <= {dq[DW-2:0], 1'b0};
          end
          if (idx == 8'(MB - 1)) begin
            idx <= '0; st <= S_DIVS;
          end else idx <= idx + 1'b1;
        end
        S_DIVS: begin
          if (idx == 8'd0) begin
            mean_r <= neg ? -$signed(mean_mag) : $signed(mean_mag);
            drem <= '0; dq <= DW'(root) << (DW - TB);
            idx <= idx + 1'b1;
          end else begin
            if (!dtrial[CB]) begin
              drem <= dtrial; dq <= {dq[DW-2:0], 1'b1};
            end else begin
              drem <= {drem[CB-1:0], dq[DW-1]}; dq <= {dq[DW-2:0], 1'b0};
            end
            if (idx == 8'(TB)) st <= S_OUT;
            else idx <= idx + 1'b1;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            res.count <= rms_pkg::OUT_BITS'(cur.n);
            res.dropped <= cur.dropped;
            if (cur.n == '0) begin
              res.mean <= '0; res.sd <= '0;
            end else begin
              res.mean <= mean_r;
              res.sd <= (sd_q > TB'({rms_pkg::OUT_BITS{1'b1}})) ?
                        {rms_pkg::OUT_BITS{1'b1}} : rms_pkg::OUT_BITS'(sd_q);
            end
            out_valid <= 1'b1; st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/running_mean_stddev_core.sv
// Top level of the running mean and standard deviation core.
// Joins rms_front and rms_back through a snapshot queue. Uses rms_pkg.
//
//  channel | valid     | stall     | payload
//  input   | in_valid  | in_stall  | op, sample
//  output  | out_valid | out_stall | count, mean_q8, stddev_q8, dropped
//
// The back end takes each item through these steps in order: taking the
// snapshot, five multiply steps for the sums, 48 square root iterations,
// 48 division steps for the mean, one setup plus 49 division steps for the
// deviation, and loading the result, before it takes the next snapshot.
// The front end updates the statistics as it accepts an item and buffers two
// snapshots; it stalls only when both are waiting. A result held by
// out_stall makes the back end wait before loading the next one.
// Reset is synchronous and clears statistics, queue and sequencer.
`timescale 1ns / 1ps
`default_nettype none
module running_mean_stddev_core (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic op,
  input  wire logic signed [15:0] sample,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [23:0] count,
  output logic signed [23:0] mean_q8,
  output logic [23:0] stddev_q8,
  output logic dropped
);
  logic q_valid, q_pop;
  rms_pkg::snap_t q_data;
  rms_pkg::res_t res;

  rms_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .sample(sample), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  rms_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .res(res)
  );

  assign count = res.count;
  assign mean_q8 = res.mean;
  assign stddev_q8 = res.sd;
  assign dropped = res.dropped;
endmodule
`default_nettype wire

FILE: rtl/rms_checker.sv
// Port checker for running_mean_stddev_core, bound to the top level.
// Depends on nothing but the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module rms_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [23:0] count,
  input wire logic [23:0] stddev_q8,
  input wire logic signed [23:0] mean_q8,
  input wire logic dropped
);
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && count == 24'd0 |-> mean_q8 == 24'sd0 && stddev_q8 == 24'd0)
    else $error("nonzero statistics with zero count");
  a_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> count == 24'hFFFFFF)
    else $error("drop reported below saturation");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(count))
    else $error("stalled result changed");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("state after reset");
endmodule

bind running_mean_stddev_core rms_checker u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .count(count),
  .stddev_q8(stddev_q8), .mean_q8(mean_q8), .dropped(dropped)
);
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for running_mean_stddev_core.
// Predicts count, mean and standard deviation per item; depends on rms_pkg.
`timescale 1ns / 1ps
module testbench;
  localparam int   LIMIT_CYCLES = 1_500_000;

  // Statistics tracker and result checker. It keeps its own copy of the
  // count, the sum and the sum of squares, and a queue of predicted results.
  class stats_scoreboard;
    logic [rms_pkg::COUNT_BITS-1:0]      n_acc;
    logic signed [rms_pkg::SUM_BITS-1:0] sum_acc;
    logic [rms_pkg::SQ_BITS-1:0]         sq_acc;
    rms_pkg::res_t                       pending[$];
    int                                  mismatches;

    function void clear_stats();
      n_acc = '0;
      sum_acc = '0;
      sq_acc = '0;
    endfunction

    // Integer square root, bit by bit, on a wide unsigned value.
    function logic [127:0] isqrt(logic [127:0] x);
      logic [127:0] root, bitv, trial;
      root = '0;
      bitv = 128'd1 << 126;
      while (bitv != 0) begin
        trial = root + bitv;
        root = root >> 1;
        if (x >= trial) begin
          x = x - trial;
          root = root + bitv;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    function void note_item(logic op, logic signed [15:0] s);
      rms_pkg::res_t r;
      logic dropped_now;
      logic [127:0] mag, q, a, b, d, sd;
      logic neg;
      dropped_now = 1'b0;
      if (op == rms_pkg::OP_CLEAR) begin
        clear_stats();
      end else if (n_acc == {rms_pkg::COUNT_BITS{1'b1}}) begin
        dropped_now = 1'b1;
      end else begin
        sum_acc = sum_acc + s;
        sq_acc  = sq_acc + rms_pkg::SQ_BITS'($unsigned(32'(s) * 32'(s)));
        n_acc   = n_acc + 1'b1;
      end
      r = '0;
      r.count = n_acc;
      r.dropped = dropped_now;
      if (n_acc != 0) begin
        neg = sum_acc < 0;
        mag = neg ? 128'(-sum_acc) : 128'(sum_acc);
        q = (mag << 8) / n_acc;
        if (q > 128'h800000) q = 128'h800000;
        if (!neg && q > 128'h7FFFFF) q = 128'h7FFFFF;
        r.mean = neg ? -q[23:0] : q[23:0];
        a = 128'(n_acc) * 128'(sq_acc);
        b = mag * mag;
        d = (a >= b) ? a - b : '0;
        sd = isqrt(d << 16) / n_acc;
        if (sd > 128'hFFFFFF) sd = 128'hFFFFFF;
        r.sd = sd[23:0];
      end
      pending.push_back(r);
    endfunction

    function void check_result(rms_pkg::res_t got);
      rms_pkg::res_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = rms_pkg::OP_ADD;
  logic signed [15:0] sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [23:0] count;
  logic signed [23:0] mean_q8;
  logic [23:0] stddev_q8;
  logic dropped;

  stats_scoreboard board;
  int cycles = 0;
  bit hold_output = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  running_mean_stddev_core dut (
    .clk, .rst, .in_valid, .in_stall, .op, .sample,
    .out_valid, .out_stall, .count, .mean_q8, .stddev_q8, .dropped
  );

  // Results are taken at the edge where valid is high and stall is low;
  // the same sampled values drive the scoreboard, so no race is possible.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall)
      board.check_result('{count: count, mean: mean_q8, sd: stddev_q8,
                           dropped: dropped});
    if (cycles > LIMIT_CYCLES) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Receiver stall: a random pattern, with calm stretches and a long forced
  // hold when asked, so that the back end fills and the input stalls.
  initial begin : receiver
    int mode;
    mode = 0;
    forever begin
      @(posedge clk);
      if (cycles % 500 == 0) mode = $urandom_range(0, 2);
      if (hold_output)
        out_stall <= 1'b1;
      else if (mode == 0)
        out_stall <= 1'b0;
      else if (mode == 1)
        out_stall <= ($urandom_range(0, 3) == 0);
      else
        out_stall <= ($urandom_range(0, 1) == 0);
    end
  end

  // Offer one item and hold it until the block accepts it. Valid stays high
  // between back to back items so it is never dropped and raised in a step.
  task automatic send_item(logic o, logic signed [15:0] s);
    in_valid <= 1'b1;
    op <= o;
    sample <= s;
    do @(posedge clk); while (in_stall);
    board.note_item(o, s);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // A burst of random items. Clears are rare so statistics build up; sample
  // ranges switch: full scale, small values, extremes and constant runs.
  task automatic random_burst(int len);
    int kind;
    logic signed [15:0] s;
    kind = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: s = 16'($urandom);
        1: s = $signed(16'($urandom_range(0, 15))) - 16'sd8;
        2: s = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
        default: s = 16'sd1234;
      endcase
      if ($urandom_range(0, 40) == 0) send_item(rms_pkg::OP_CLEAR, 16'($urandom));
      else send_item(rms_pkg::OP_ADD, s);
    end
  endtask

  initial begin : stimulus
    int sent;
    board = new();
    board.clear_stats();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty stats, clear with garbage sample, extremes, one sample
    // giving zero deviation, alternating extremes for the largest deviation.
    send_item(rms_pkg::OP_CLEAR, 16'shFFFF);
    send_item(rms_pkg::OP_ADD, 16'sh7FFF);
    send_item(rms_pkg::OP_ADD, 16'sh7FFF);
    send_item(rms_pkg::OP_ADD, 16'sh8000);
    send_item(rms_pkg::OP_ADD, 16'sh8000);
    send_item(rms_pkg::OP_ADD, 16'sd0);
    send_item(rms_pkg::OP_ADD, -16'sd1);
    send_item(rms_pkg::OP_CLEAR, 16'sh5555);
    send_item(rms_pkg::OP_ADD, -16'sd1);
    send_item(rms_pkg::OP_ADD, -16'sd2);
    send_item(rms_pkg::OP_ADD, 16'sd1);
    send_item(rms_pkg::OP_CLEAR, 16'shAAAA);
    send_item(rms_pkg::OP_ADD, 16'sh8000);
    send_item(rms_pkg::OP_ADD, 16'sh7FFF);
    send_item(rms_pkg::OP_ADD, 16'sh8000);
    send_item(rms_pkg::OP_ADD, 16'sh7FFF);
    send_item(rms_pkg::OP_ADD, 16'sh5A5A);
    send_item(rms_pkg::OP_ADD, 16'shA5A5);

    // Sender pauses until every expected result is back.
    drain();

    // Long receiver hold while items keep coming, so the input stalls.
    fork
      begin
        hold_output = 1'b1;
        repeat (2000) @(posedge clk);
        hold_output = 1'b0;
      end
      random_burst(12);
    join

    sent = 0;
    while (sent < 1200) begin
      int len;
      len = $urandom_range(1, 30);
      random_burst(len);
      sent += len;
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 400));
    end

    drain();
    repeat (400) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end
endmodule
